// ----- sv/aar_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the axis-angle rotation block.
// Used by every module of the block; depends on nothing.
package aar_pkg;

    localparam logic [30:0] ONE30        = 31'h4000_0000;
    localparam logic [18:0] RAD_PER_UNIT = 19'd292818;
    localparam logic signed [17:0] FULL_TURN    = 18'sd23040;
    localparam logic [14:0] QUARTER_TURN = 15'd5760;
    localparam logic [14:0] EIGHTH_TURN  = 15'd2880;
    localparam logic [15:0] Q14_ONE      = 16'd16384;

    typedef struct packed {
        logic        degen;
        logic        sx;
        logic        sy;
        logic        sz;
        logic [16:0] mx;
        logic [16:0] my;
        logic [16:0] mz;
        logic [31:0] n2;
        logic [1:0]  quad;
        logic        swap;
        logic [11:0] t;
    } t_job;

    typedef struct packed {
        logic             degen;
        logic [8:0][15:0] ent;
    } t_mat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_UDIV,
        ST_TH,
        ST_U,
        ST_SDIV,
        ST_SMUL,
        ST_SFIN,
        ST_CDIV,
        ST_CMUL,
        ST_CLAST,
        ST_QUAD,
        ST_MAT,
        ST_DONE
    } t_state;

    // Reciprocals ceil(2^s / d) for the series divisors; exact for dividends below 2^30.
    function automatic logic [31:0] f_sin_recip(input logic [1:0] k);
        logic [31:0] m;
        case (k)
            2'd0:    m = 32'd1908874354;
            2'd1:    m = 32'd1636178018;
            2'd2:    m = 32'd1717986919;
            default: m = 32'd1431655766;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] f_sin_shift(input logic [1:0] k);
        logic [5:0] s;
        case (k)
            2'd0:    s = 6'd37;
            2'd1:    s = 6'd36;
            2'd2:    s = 6'd35;
            default: s = 6'd33;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] f_cos_recip(input logic [1:0] k);
        logic [31:0] m;
        case (k)
            2'd0:    m = 32'd1227133514;
            2'd1:    m = 32'd1145324613;
            default: m = 32'd1431655766;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] f_cos_shift(input logic [1:0] k);
        logic [5:0] s;
        case (k)
            2'd0:    s = 6'd36;
            2'd1:    s = 6'd35;
            default: s = 6'd34;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] f_to_q14(input logic signed [36:0] v);
        logic [36:0] mag;
        logic [36:0] rnd;
        logic [20:0] r;
        logic [15:0] res;
        mag = v[36] ? 37'(-v) : 37'(v);
        rnd = mag + 37'd32768;
        r   = rnd[36:16];
        if (v[36]) begin
            res = (r > 21'd32768) ? 16'h8000 : 16'(21'd0 - r);
        end else begin
            res = (r > 21'd32767) ? 16'h7fff : r[15:0];
        end
        return res;
    endfunction

endpackage

// ----- sv/aar_front.sv -----
`timescale 1ns / 1ps
// Input stage: registers an axis-angle word and classifies it into a job.
// Depends on aar_pkg.
module aar_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    input  logic signed [15:0] i_angle_deg,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output aar_pkg::t_job     o_job
);

    logic               r_valid;
    logic signed [15:0] r_x, r_y, r_z, r_ang;
    logic signed [17:0] a0, a1;
    logic [14:0]        a, r;
    logic [1:0]         quad;
    logic [33:0]        n2;

    assign o_ready     = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x   <= i_axis_x;
            r_y   <= i_axis_y;
            r_z   <= i_axis_z;
            r_ang <= i_angle_deg;
        end
    end

    always_comb begin
        o_job.sx = r_x[15];
        o_job.sy = r_y[15];
        o_job.sz = r_z[15];
        o_job.mx = r_x[15] ? 17'(-18'(r_x)) : 17'(r_x);
        o_job.my = r_y[15] ? 17'(-18'(r_y)) : 17'(r_y);
        o_job.mz = r_z[15] ? 17'(-18'(r_z)) : 17'(r_z);
        n2 = 34'(o_job.mx * o_job.mx) + 34'(o_job.my * o_job.my)
           + 34'(o_job.mz * o_job.mz);
        o_job.n2    = n2[31:0];
        o_job.degen = (n2 == 34'd0);

        a0 = 18'(r_ang);
        if (a0 < 0) begin
            a1 = a0 + aar_pkg::FULL_TURN;
            if (a1 < 0) begin
                a1 = a1 + aar_pkg::FULL_TURN;
            end
        end else if (a0 >= aar_pkg::FULL_TURN) begin
            a1 = a0 - aar_pkg::FULL_TURN;
        end else begin
            a1 = a0;
        end
        a = a1[14:0];

        if (a >= 15'd17280) begin
            quad = 2'd3;
            r    = a - 15'd17280;
        end else if (a >= 15'd11520) begin
            quad = 2'd2;
            r    = a - 15'd11520;
        end else if (a >= aar_pkg::QUARTER_TURN) begin
            quad = 2'd1;
            r    = a - aar_pkg::QUARTER_TURN;
        end else begin
            quad = 2'd0;
            r    = a;
        end
        o_job.quad = quad;
        o_job.swap = (r > aar_pkg::EIGHTH_TURN);
        o_job.t    = o_job.swap ? 12'(aar_pkg::QUARTER_TURN - r) : r[11:0];
    end

endmodule

// ----- sv/aar_queue.sv -----
`timescale 1ns / 1ps
// Two-entry job queue between the classifier and the matrix engine.
// Depends on aar_pkg.
module aar_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  aar_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output aar_pkg::t_job o_job
);

    aar_pkg::t_job r_mem [2];
    logic          r_wr, r_rd;
    logic [1:0]    r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- sv/aar_back.sv -----
`timescale 1ns / 1ps
// Matrix engine: square root, unit divisions on a radix-2 divider, sine and cosine
// series and the Rodrigues products on one shared multiplier. Depends on aar_pkg.
module aar_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  aar_pkg::t_job i_job,
    output logic          o_mat_valid,
    input  logic          i_mat_ready,
    output aar_pkg::t_mat o_mat
);

    aar_pkg::t_state    r_state, n_state;
    aar_pkg::t_job      r_job, n_job;
    logic [4:0]         r_cnt, n_cnt;
    logic [1:0]         r_idx, n_idx;
    logic [63:0]        r_v, n_v, r_res, n_res;
    logic [31:0]        r_rem, n_rem, r_dvs, n_dvs;
    logic [30:0]        r_dq, n_dq;
    logic [30:0]        r_ux, n_ux, r_uy, n_uy, r_uz, n_uz;
    logic [29:0]        r_th, n_th, r_u, n_u;
    logic [30:0]        r_f, n_f, r_sin, n_sin, r_cos, n_cos, r_smag, n_smag;
    logic               r_sneg, n_sneg;
    logic signed [31:0] r_c, n_c;
    logic [31:0]        r_omc, n_omc;
    logic [31:0]        r_pp [6];
    logic [31:0]        n_pp [6];
    logic signed [35:0] r_mo [6];
    logic signed [35:0] n_mo [6];
    logic signed [35:0] r_sn [3];
    logic signed [35:0] n_sn [3];

    logic [31:0]        opa, opb;
    logic [63:0]        prod;
    logic               msgn;
    logic signed [35:0] mval;
    logic [63:0]        bitv, trial;
    logic [32:0]        rs;
    logic               ge;
    logic [30:0]        quot, s0, c0, p31;
    logic signed [32:0] omc33;
    logic signed [35:0] c36;
    logic [5:0]         sh;
    logic [63:0]        shp;

    assign o_job_ready = (r_state == aar_pkg::ST_IDLE);
    assign o_mat_valid = (r_state == aar_pkg::ST_DONE);
    assign prod        = 64'(opa) * 64'(opb);
    assign mval        = msgn ? -$signed({2'b00, prod[63:30]}) : $signed({2'b00, prod[63:30]});
    assign p31         = prod[60:30];

    assign bitv  = 64'd1 << {r_cnt, 1'b0};
    assign trial = r_res + bitv;
    assign rs    = {r_rem, r_dq[30]};
    assign ge    = (rs >= {1'b0, r_dvs});
    assign quot  = {r_dq[29:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aar_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        r_v    <= n_v;
        r_res  <= n_res;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_dq   <= n_dq;
        r_ux   <= n_ux;
        r_uy   <= n_uy;
        r_uz   <= n_uz;
        r_th   <= n_th;
        r_u    <= n_u;
        r_f    <= n_f;
        r_sin  <= n_sin;
        r_cos  <= n_cos;
        r_smag <= n_smag;
        r_sneg <= n_sneg;
        r_c    <= n_c;
        r_omc  <= n_omc;
        r_pp   <= n_pp;
        r_mo   <= n_mo;
        r_sn   <= n_sn;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aar_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.degen ? aar_pkg::ST_DONE : aar_pkg::ST_SQRT;
                end
            end
            aar_pkg::ST_SQRT: begin
                if (r_cnt == 5'd0) begin
                    n_state = aar_pkg::ST_UDIV;
                end
            end
            aar_pkg::ST_UDIV: begin
                if (r_cnt == 5'd0 && r_idx == 2'd2) begin
                    n_state = aar_pkg::ST_TH;
                end
            end
            aar_pkg::ST_TH: n_state = aar_pkg::ST_U;
            aar_pkg::ST_U:  n_state = aar_pkg::ST_SDIV;
            aar_pkg::ST_SDIV: begin
                n_state = (r_idx == 2'd3) ? aar_pkg::ST_SFIN : aar_pkg::ST_SMUL;
            end
            aar_pkg::ST_SMUL: n_state = aar_pkg::ST_SDIV;
            aar_pkg::ST_SFIN: n_state = aar_pkg::ST_CDIV;
            aar_pkg::ST_CDIV: begin
                n_state = (r_idx == 2'd2) ? aar_pkg::ST_CLAST : aar_pkg::ST_CMUL;
            end
            aar_pkg::ST_CMUL:  n_state = aar_pkg::ST_CDIV;
            aar_pkg::ST_CLAST: n_state = aar_pkg::ST_QUAD;
            aar_pkg::ST_QUAD:  n_state = aar_pkg::ST_MAT;
            aar_pkg::ST_MAT: begin
                if (r_cnt == 5'd14) begin
                    n_state = aar_pkg::ST_DONE;
                end
            end
            aar_pkg::ST_DONE: begin
                if (i_mat_ready) begin
                    n_state = aar_pkg::ST_IDLE;
                end
            end
            default: n_state = aar_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_job  = r_job;
        n_cnt  = r_cnt;
        n_idx  = r_idx;
        n_v    = r_v;
        n_res  = r_res;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_dq   = r_dq;
        n_ux   = r_ux;
        n_uy   = r_uy;
        n_uz   = r_uz;
        n_th   = r_th;
        n_u    = r_u;
        n_f    = r_f;
        n_sin  = r_sin;
        n_cos  = r_cos;
        n_smag = r_smag;
        n_sneg = r_sneg;
        n_c    = r_c;
        n_omc  = r_omc;
        n_pp   = r_pp;
        n_mo   = r_mo;
        n_sn   = r_sn;
        opa    = 32'd0;
        opb    = 32'd0;
        msgn   = 1'b0;
        s0     = 31'd0;
        c0     = 31'd0;
        omc33  = 33'sd0;
        sh     = 6'd0;
        shp    = 64'd0;

        unique case (r_state)
            aar_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    n_job = i_job;
                    n_v   = 64'({i_job.n2, 30'd0});
                    n_res = 64'd0;
                    n_cnt = 5'd31;
                end
            end
            aar_pkg::ST_SQRT: begin
                if (r_v >= trial) begin
                    n_v   = r_v - trial;
                    n_res = (r_res >> 1) + bitv;
                end else begin
                    n_res = r_res >> 1;
                end
                if (r_cnt == 5'd0) begin
                    n_idx = 2'd0;
                    n_cnt = 5'd30;
                    n_rem = {1'b0, r_job.mx, 14'd0};
                    n_dq  = 31'd0;
                    n_dvs = n_res[31:0];
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            aar_pkg::ST_UDIV: begin
                n_rem = ge ? 32'(rs - {1'b0, r_dvs}) : rs[31:0];
                n_dq  = quot;
                if (r_cnt != 5'd0) begin
                    n_cnt = r_cnt - 5'd1;
                end else begin
                    case (r_idx)
                        2'd0:    n_ux = quot;
                        2'd1:    n_uy = quot;
                        default: n_uz = quot;
                    endcase
                    n_idx = r_idx + 2'd1;
                    n_cnt = 5'd30;
                    n_rem = {1'b0, ((r_idx == 2'd0) ? r_job.my : r_job.mz), 14'd0};
                    n_dq  = 31'd0;
                end
            end
            aar_pkg::ST_SDIV, aar_pkg::ST_CDIV: begin
                opa = 32'(r_dq);
                opb = r_dvs;
                sh  = (r_state == aar_pkg::ST_SDIV) ? aar_pkg::f_sin_shift(r_idx)
                                                    : aar_pkg::f_cos_shift(r_idx);
                shp = prod >> sh;
                n_f = aar_pkg::ONE30 - {1'b0, shp[29:0]};
            end
            aar_pkg::ST_TH: begin
                opa  = 32'(r_job.t);
                opb  = 32'(aar_pkg::RAD_PER_UNIT);
                n_th = prod[29:0];
            end
            aar_pkg::ST_U: begin
                opa   = 32'(r_th);
                opb   = 32'(r_th);
                n_u   = prod[59:30];
                n_idx = 2'd0;
                n_dq  = {1'b0, prod[59:30]};
                n_dvs = aar_pkg::f_sin_recip(2'd0);
            end
            aar_pkg::ST_SMUL, aar_pkg::ST_CMUL: begin
                opa   = 32'(r_u);
                opb   = 32'(r_f);
                n_idx = r_idx + 2'd1;
                n_dq  = p31;
                n_dvs = (r_state == aar_pkg::ST_SMUL) ? aar_pkg::f_sin_recip(r_idx + 2'd1)
                                                      : aar_pkg::f_cos_recip(r_idx + 2'd1);
            end
            aar_pkg::ST_SFIN: begin
                opa   = 32'(r_th);
                opb   = 32'(r_f);
                n_sin = p31;
                n_idx = 2'd0;
                n_dq  = {1'b0, r_u};
                n_dvs = aar_pkg::f_cos_recip(2'd0);
            end
            aar_pkg::ST_CLAST: begin
                opa   = 32'(r_u);
                opb   = 32'(r_f);
                n_cos = aar_pkg::ONE30 - (p31 >> 1);
            end
            aar_pkg::ST_QUAD: begin
                s0 = r_job.swap ? r_cos : r_sin;
                c0 = r_job.swap ? r_sin : r_cos;
                case (r_job.quad)
                    2'd0: begin
                        n_smag = s0;
                        n_sneg = 1'b0;
                        n_c    = 32'(c0);
                    end
                    2'd1: begin
                        n_smag = c0;
                        n_sneg = 1'b0;
                        n_c    = -32'(s0);
                    end
                    2'd2: begin
                        n_smag = s0;
                        n_sneg = 1'b1;
                        n_c    = -32'(c0);
                    end
                    default: begin
                        n_smag = c0;
                        n_sneg = 1'b1;
                        n_c    = 32'(s0);
                    end
                endcase
                omc33 = 33'sh0_4000_0000 - 33'(n_c);
                n_omc = omc33[31:0];
                n_cnt = 5'd0;
            end
            aar_pkg::ST_MAT: begin
                case (r_cnt)
                    5'd0: begin opa = 32'(r_ux); opb = 32'(r_ux); end
                    5'd1: begin opa = 32'(r_uy); opb = 32'(r_uy); end
                    5'd2: begin opa = 32'(r_uz); opb = 32'(r_uz); end
                    5'd3: begin opa = 32'(r_ux); opb = 32'(r_uy); end
                    5'd4: begin opa = 32'(r_ux); opb = 32'(r_uz); end
                    5'd5: begin opa = 32'(r_uy); opb = 32'(r_uz); end
                    5'd6: begin opa = r_pp[0]; opb = r_omc; end
                    5'd7: begin opa = r_pp[1]; opb = r_omc; end
                    5'd8: begin opa = r_pp[2]; opb = r_omc; end
                    5'd9: begin opa = r_pp[3]; opb = r_omc; msgn = r_job.sx ^ r_job.sy; end
                    5'd10: begin opa = r_pp[4]; opb = r_omc; msgn = r_job.sx ^ r_job.sz; end
                    5'd11: begin opa = r_pp[5]; opb = r_omc; msgn = r_job.sy ^ r_job.sz; end
                    5'd12: begin opa = 32'(r_ux); opb = 32'(r_smag); msgn = r_job.sx ^ r_sneg; end
                    5'd13: begin opa = 32'(r_uy); opb = 32'(r_smag); msgn = r_job.sy ^ r_sneg; end
                    default: begin opa = 32'(r_uz); opb = 32'(r_smag); msgn = r_job.sz ^ r_sneg; end
                endcase
                case (r_cnt)
                    5'd0:  n_pp[0] = prod[61:30];
                    5'd1:  n_pp[1] = prod[61:30];
                    5'd2:  n_pp[2] = prod[61:30];
                    5'd3:  n_pp[3] = prod[61:30];
                    5'd4:  n_pp[4] = prod[61:30];
                    5'd5:  n_pp[5] = prod[61:30];
                    5'd6:  n_mo[0] = mval;
                    5'd7:  n_mo[1] = mval;
                    5'd8:  n_mo[2] = mval;
                    5'd9:  n_mo[3] = mval;
                    5'd10: n_mo[4] = mval;
                    5'd11: n_mo[5] = mval;
                    5'd12: n_sn[0] = mval;
                    5'd13: n_sn[1] = mval;
                    default: n_sn[2] = mval;
                endcase
                n_cnt = r_cnt + 5'd1;
            end
            aar_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign c36 = 36'(r_c);

    always_comb begin
        o_mat.degen = r_job.degen;
        if (r_job.degen) begin
            o_mat.ent    = '0;
            o_mat.ent[0] = aar_pkg::Q14_ONE;
            o_mat.ent[4] = aar_pkg::Q14_ONE;
            o_mat.ent[8] = aar_pkg::Q14_ONE;
        end else begin
            o_mat.ent[0] = aar_pkg::f_to_q14(37'(r_mo[0]) + 37'(c36));
            o_mat.ent[1] = aar_pkg::f_to_q14(37'(r_mo[3]) - 37'(r_sn[2]));
            o_mat.ent[2] = aar_pkg::f_to_q14(37'(r_mo[4]) + 37'(r_sn[1]));
            o_mat.ent[3] = aar_pkg::f_to_q14(37'(r_mo[3]) + 37'(r_sn[2]));
            o_mat.ent[4] = aar_pkg::f_to_q14(37'(r_mo[1]) + 37'(c36));
            o_mat.ent[5] = aar_pkg::f_to_q14(37'(r_mo[5]) - 37'(r_sn[0]));
            o_mat.ent[6] = aar_pkg::f_to_q14(37'(r_mo[4]) - 37'(r_sn[1]));
            o_mat.ent[7] = aar_pkg::f_to_q14(37'(r_mo[5]) + 37'(r_sn[0]));
            o_mat.ent[8] = aar_pkg::f_to_q14(37'(r_mo[2]) + 37'(c36));
        end
    end

endmodule

// ----- sv/aar_emit.sv -----
`timescale 1ns / 1ps
// Output stage: holds one finished matrix and sends it as four row words.
// Depends on aar_pkg.
module aar_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_mat_valid,
    output logic              o_mat_ready,
    input  aar_pkg::t_mat     i_mat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_row_index,
    output logic signed [15:0] o_col0,
    output logic signed [15:0] o_col1,
    output logic signed [15:0] o_col2,
    output logic signed [15:0] o_col3,
    output logic              o_degenerate,
    output logic              o_last
);

    logic          r_busy;
    logic [1:0]    r_row;
    aar_pkg::t_mat r_mat;
    logic          load;

    assign o_mat_ready = !r_busy || (i_ready && r_row == 2'd3);
    assign load        = i_mat_valid && o_mat_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= 2'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_row  <= 2'd0;
        end else if (r_busy && i_ready) begin
            r_row  <= r_row + 2'd1;
            r_busy <= (r_row != 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mat <= i_mat;
        end
    end

    always_comb begin
        o_valid      = r_busy;
        o_row_index  = r_row;
        o_degenerate = r_mat.degen;
        o_last       = (r_row == 2'd3);
        o_col3       = 16'd0;
        case (r_row)
            2'd0: begin
                o_col0 = r_mat.ent[0];
                o_col1 = r_mat.ent[1];
                o_col2 = r_mat.ent[2];
            end
            2'd1: begin
                o_col0 = r_mat.ent[3];
                o_col1 = r_mat.ent[4];
                o_col2 = r_mat.ent[5];
            end
            2'd2: begin
                o_col0 = r_mat.ent[6];
                o_col1 = r_mat.ent[7];
                o_col2 = r_mat.ent[8];
            end
            default: begin
                o_col0 = 16'd0;
                o_col1 = 16'd0;
                o_col2 = 16'd0;
                o_col3 = aar_pkg::Q14_ONE;
            end
        endcase
    end

endmodule

// ----- sv/axis_angle_rotation_matrix.sv -----
`timescale 1ns / 1ps
// Axis-angle to 4x4 rotation matrix (Rodrigues), Q2.14 entries.
// Depends on aar_pkg, aar_front, aar_queue, aar_back and aar_emit.
//
// Input channel: one word carries axis x, y, z and an angle in 1/64 degree,
// taken when i_valid and o_ready are both high. Output channel: four words per
// input, rows 0 to 3 in order, o_last on row 3, taken when o_valid and i_ready
// are both high. A zero-length axis gives the identity with o_degenerate set.
// The input register and a two-entry job queue let new words in while the
// engine works and while a finished matrix waits in the output stage.
// The engine runs one job at a time on one shared 32x32 multiplier and one
// radix-2 divider: 32 square-root steps, three 31-step unit divisions and the
// multiply steps (series divisions by reciprocal), after taking the job in its
// idle state and before handing over the matrix from its done state; a
// zero-length axis goes straight from idle to done, so a run of them is paced
// by the four output rows. The engine takes no new job until it has handed
// over the matrix, and the four rows then leave at one per cycle while
// i_ready is high.
// A stalled receiver holds the current row; the engine stops once its result
// cannot be handed over; queue and input register fill, and o_ready drops.
// Synchronous reset empties the input register, the queue and the output stage.
module axis_angle_rotation_matrix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    input  logic signed [15:0] i_angle_deg,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_row_index,
    output logic signed [15:0] o_col0,
    output logic signed [15:0] o_col1,
    output logic signed [15:0] o_col2,
    output logic signed [15:0] o_col3,
    output logic              o_degenerate,
    output logic              o_last
);

    aar_pkg::t_job f_job, q_job;
    aar_pkg::t_mat b_mat;
    logic          f_valid, f_ready, q_valid, q_ready, b_valid, b_ready;

    aar_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_axis_x    (i_axis_x),
        .i_axis_y    (i_axis_y),
        .i_axis_z    (i_axis_z),
        .i_angle_deg (i_angle_deg),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    aar_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    aar_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .o_mat_valid (b_valid),
        .i_mat_ready (b_ready),
        .o_mat       (b_mat)
    );

    aar_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mat_valid  (b_valid),
        .o_mat_ready  (b_ready),
        .i_mat        (b_mat),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_row_index  (o_row_index),
        .o_col0       (o_col0),
        .o_col1       (o_col1),
        .o_col2       (o_col2),
        .o_col3       (o_col3),
        .o_degenerate (o_degenerate),
        .o_last       (o_last)
    );

endmodule
